// ===== rtl/core/hhnf_pkg.sv =====
package hhnf_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // result kinds
  localparam logic [1:0] EV_FOUND  = 2'd0;
  localparam logic [1:0] EV_END    = 2'd1;
  localparam logic [1:0] EV_STATUS = 2'd2;

  // buffer status codes
  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_LINE_END = 2'd1;
  localparam logic [1:0] ST_UNTERM   = 2'd2;

  // register indexes (byte address 8*index)
  localparam logic [2:0] REG_NAME0   = 3'd0;
  localparam logic [2:0] REG_NAME1   = 3'd1;
  localparam logic [2:0] REG_NAME2   = 3'd2;
  localparam logic [2:0] REG_NAME3   = 3'd3;
  localparam logic [2:0] REG_LENGTHS = 3'd4;
  localparam logic [2:0] REG_ENABLE  = 3'd5;

  // result queue depth
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

  // per-name compare outcome for the current byte
  typedef struct packed {
    logic hit;   // name complete and this byte is a colon
    logic kill;  // name drops out of the candidate set
  } match_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  name_index;
    logic [15:0] offset;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // ascii fold to lower case
  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41:8'h5A]}) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hhnf_name_match.sv =====
module hhnf_name_match #(
  parameter int NAME_BYTES = 8
) (
  input  logic [63:0]           name_i,
  input  logic [3:0]            len_i,
  input  logic [3:0]            column_i,
  input  logic [7:0]            byte_i,
  output hhnf_pkg::match_t      match_o
);

  logic [3:0] len_c;
  logic [7:0] name_byte;

  // clamp length to the name storage
  assign len_c = (len_i > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : len_i;

  // column is below len_c (at most 8) whenever this byte is used
  assign name_byte = name_i[{column_i[2:0], 3'b000} +: 8];

  // compare inside the name, colon check right after it
  always_comb begin
    match_o.hit  = 1'b0;
    match_o.kill = 1'b1;
    if (column_i < len_c) begin
      match_o.kill = hhnf_pkg::lower_ascii(byte_i) != hhnf_pkg::lower_ascii(name_byte);
    end else begin
      match_o.hit = (column_i == len_c) && (byte_i == hhnf_pkg::CH_COLON);
    end
  end

endmodule

// ===== rtl/core/hhnf_result_fifo.sv =====
module hhnf_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push0_i,
  input  hhnf_pkg::result_t   data0_i,
  input  logic                push1_i,
  input  hhnf_pkg::result_t   data1_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output hhnf_pkg::result_t   data_o
);

  localparam int CNT_W = $clog2(hhnf_pkg::RQ_DEPTH + 1);

  hhnf_pkg::result_t              mem_r [hhnf_pkg::RQ_DEPTH];
  logic [hhnf_pkg::RQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [hhnf_pkg::RQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           pop;
  logic [CNT_W-1:0]               push_cnt;

  // room for two results, ignoring a pop in the same cycle
  assign room_o  = count_r <= CNT_W'(hhnf_pkg::RQ_DEPTH - 2);
  assign valid_o = count_r != '0;
  assign data_o  = mem_r[rd_ptr_r];
  assign pop     = valid_o && ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    push_cnt   = CNT_W'(push0_i) + CNT_W'(push1_i);
    wr_ptr_nxt = wr_ptr_r + hhnf_pkg::RQ_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + hhnf_pkg::RQ_PTR_W'(pop);
    count_nxt  = count_r + push_cnt - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push0_i) begin
      mem_r[wr_ptr_r] <= data0_i;
    end
    if (push1_i) begin
      mem_r[wr_ptr_r + hhnf_pkg::RQ_PTR_W'(1)] <= data1_i;
    end
  end

endmodule

// ===== rtl/core/http_header_name_finder.sv =====
// HTTP header name finder. Takes a header buffer one byte per request on the in_ stream
// (tlast marks the buffer's last byte) and, ignoring letter case, matches each line
// against four configured names of up to eight bytes followed by a colon. A name found
// on a line closed by CR LF yields a found result with the line's start offset, once
// per name; a bare CR LF line yields an end-of-headers result; the last byte of each
// buffer yields a status result. A byte is taken every cycle while the result queue has room
// for two results: it is registered, worked on against all names at once, and its results
// go into a four-entry result queue. A byte that causes two results (a closed line or the
// blank line on a buffer's last byte) occupies two queue slots, and the queue drains one
// result per cycle while the output is ready, so the input slows only while such bytes
// follow each other or the output stalls.
module http_header_name_finder #(
  parameter int NAME_COUNT  = 4,
  parameter int NAME_BYTES  = 8,
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // buffer_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] name_index, [17:2] offset, [19:18] status, zero
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast,  // final_res
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ACT_NAMES = (NAME_COUNT < 4) ? NAME_COUNT : 4;
  localparam logic [3:0] ACT_MASK = 4'((1 << ACT_NAMES) - 1);

  // buffer-start phase
  localparam logic [1:0] LEAD_NONE  = 2'd0;
  localparam logic [1:0] LEAD_CR    = 2'd1;
  localparam logic [1:0] LEAD_LF    = 2'd2;
  localparam logic [1:0] LEAD_START = 2'd3;

  // halt codes
  localparam logic [1:0] HALT_RUN  = 2'd0;
  localparam logic [1:0] HALT_LFCR = 2'd1;
  localparam logic [1:0] HALT_NUL  = 2'd2;

  // configuration registers
  logic [63:0] name_r [4];
  logic [15:0] lengths_r;
  logic [3:0]  enable_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // input register
  logic        stage_valid_r, stage_valid_nxt;
  logic [7:0]  stage_byte_r;
  logic        stage_fin_r;
  logic        in_acc;
  logic        fire;
  logic        room;

  // scan state
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] lso_r, lso_nxt, lso_e;
  logic [3:0]             col_r, col_nxt;
  logic [3:0]             cand_r, cand_nxt, cand_e;
  logic [3:0]             found_r, found_nxt;
  logic                   matched_r, matched_nxt, matched_e;
  logic [1:0]             idx_r, idx_nxt, idx_e;
  logic                   sawcr_r, sawcr_nxt, sawcr_e;
  logic                   done_r, done_nxt;
  logic [1:0]             lead_r, lead_nxt;
  logic [1:0]             halt_r, halt_nxt;

  // per-byte work
  hhnf_pkg::match_t  match [4];
  logic [3:0]        hit_v;
  logic [3:0]        kill_v;
  logic              hit_any;
  logic [1:0]        hit_low;
  logic              col_zero;
  logic              skip;
  logic              ev_valid;
  logic [1:0]        ev_kind;
  logic [1:0]        status;
  logic [15:0]       off16;
  logic              push0, push1;
  hhnf_pkg::result_t res0, res1, res_out;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        name_r[i] <= '0;
      end
      lengths_r <= '0;
      enable_r  <= 4'hF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hhnf_pkg::REG_NAME0:   name_r[0] <= cfg_pwdata;
        hhnf_pkg::REG_NAME1:   name_r[1] <= cfg_pwdata;
        hhnf_pkg::REG_NAME2:   name_r[2] <= cfg_pwdata;
        hhnf_pkg::REG_NAME3:   name_r[3] <= cfg_pwdata;
        hhnf_pkg::REG_LENGTHS: lengths_r <= cfg_pwdata[15:0];
        hhnf_pkg::REG_ENABLE:  enable_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      hhnf_pkg::REG_NAME0:   cfg_prdata = name_r[0];
      hhnf_pkg::REG_NAME1:   cfg_prdata = name_r[1];
      hhnf_pkg::REG_NAME2:   cfg_prdata = name_r[2];
      hhnf_pkg::REG_NAME3:   cfg_prdata = name_r[3];
      hhnf_pkg::REG_LENGTHS: cfg_prdata = {48'd0, lengths_r};
      hhnf_pkg::REG_ENABLE:  cfg_prdata = {60'd0, enable_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // input register handshake
  assign fire      = stage_valid_r && room;
  assign in_tready = !stage_valid_r || room;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_acc) begin
      stage_valid_nxt = 1'b1;
    end else if (fire) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_byte_r <= in_tdata;
      stage_fin_r  <= in_tlast;
    end
  end

  // line state as seen by this byte, after a new line opens
  assign col_zero  = col_r == 4'd0;
  assign lso_e     = col_zero ? pos_r : lso_r;
  assign cand_e    = col_zero ? (enable_r & ~found_r & ACT_MASK) : cand_r;
  assign matched_e = col_zero ? 1'b0 : matched_r;
  assign idx_e     = col_zero ? 2'd0 : idx_r;
  assign sawcr_e   = col_zero ? 1'b0 : sawcr_r;

  // name compare lanes
  for (genvar g = 0; g < 4; g++) begin : g_name
    hhnf_name_match #(
      .NAME_BYTES(NAME_BYTES)
    ) u_match (
      .name_i  (name_r[g]),
      .len_i   (lengths_r[4*g +: 4]),
      .column_i(col_r),
      .byte_i  (stage_byte_r),
      .match_o (match[g])
    );
    assign hit_v[g]  = cand_e[g] && match[g].hit;
    assign kill_v[g] = cand_e[g] && match[g].kill;
  end

  // lowest-index hit on this byte
  always_comb begin
    hit_any = |hit_v;
    hit_low = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (hit_v[i]) begin
        hit_low = 2'(i);
      end
    end
  end

  // offset field view
  if (OFFSET_BITS >= 16) begin : g_off_wide
    assign off16 = lso_e[15:0];
  end else begin : g_off_narrow
    assign off16 = {{(16 - OFFSET_BITS){1'b0}}, lso_e};
  end

  // byte step
  always_comb begin
    pos_nxt     = pos_r + OFFSET_BITS'(1);
    lso_nxt     = lso_r;
    col_nxt     = col_r;
    cand_nxt    = cand_r;
    found_nxt   = found_r;
    matched_nxt = matched_r;
    idx_nxt     = idx_r;
    sawcr_nxt   = sawcr_r;
    done_nxt    = done_r;
    lead_nxt    = lead_r;
    halt_nxt    = halt_r;
    skip        = 1'b0;
    ev_valid    = 1'b0;
    ev_kind     = hhnf_pkg::EV_FOUND;

    if (!done_r && halt_r == HALT_RUN) begin
      // leading line-break skip at buffer start
      case (lead_r)
        LEAD_START: begin
          lead_nxt = LEAD_NONE;
          if (!stage_fin_r && stage_byte_r == hhnf_pkg::CH_CR) begin
            lead_nxt = LEAD_CR;
            skip     = 1'b1;
          end else if (!stage_fin_r && stage_byte_r == hhnf_pkg::CH_LF) begin
            lead_nxt = LEAD_LF;
            skip     = 1'b1;
          end
        end
        LEAD_CR: begin
          lead_nxt = LEAD_NONE;
          skip     = stage_byte_r == hhnf_pkg::CH_LF;
        end
        LEAD_LF: begin
          lead_nxt = LEAD_NONE;
          if (stage_byte_r == hhnf_pkg::CH_CR) begin
            halt_nxt = HALT_LFCR;
            skip     = 1'b1;
          end
        end
        default: ;
      endcase

      if (!skip) begin
        // new line opens
        if (col_zero) begin
          lso_nxt     = lso_e;
          cand_nxt    = cand_e;
          matched_nxt = 1'b0;
          idx_nxt     = 2'd0;
          sawcr_nxt   = 1'b0;
        end
        if (!(col_zero && stage_fin_r)) begin
          if (stage_byte_r == hhnf_pkg::CH_NUL) begin
            halt_nxt = HALT_NUL;
          end else if (sawcr_e && stage_byte_r == hhnf_pkg::CH_LF) begin
            // line closed
            if (col_r == 4'd1) begin
              ev_valid = 1'b1;
              ev_kind  = hhnf_pkg::EV_END;
              done_nxt = 1'b1;
            end else if (matched_e) begin
              ev_valid  = 1'b1;
              ev_kind   = hhnf_pkg::EV_FOUND;
              found_nxt = found_r | (4'd1 << idx_e);
            end
            col_nxt     = 4'd0;
            sawcr_nxt   = 1'b0;
            matched_nxt = 1'b0;
          end else begin
            // name compare step
            cand_nxt = cand_e & ~kill_v;
            if (hit_any && (!matched_e || hit_low < idx_e)) begin
              matched_nxt = 1'b1;
              idx_nxt     = hit_low;
            end
            sawcr_nxt = stage_byte_r == hhnf_pkg::CH_CR;
            if (col_r != 4'd15) begin
              col_nxt = col_r + 4'd1;
            end
          end
        end
      end
    end

    // buffer status from the state this byte leaves
    if (done_nxt || halt_nxt == HALT_LFCR) begin
      status = hhnf_pkg::ST_COMPLETE;
    end else if (halt_nxt == HALT_NUL || col_nxt != 4'd0) begin
      status = hhnf_pkg::ST_UNTERM;
    end else begin
      status = hhnf_pkg::ST_LINE_END;
    end

    // buffer end clears the per-buffer state
    if (stage_fin_r) begin
      pos_nxt     = '0;
      lso_nxt     = '0;
      col_nxt     = 4'd0;
      cand_nxt    = 4'hF;
      matched_nxt = 1'b0;
      idx_nxt     = 2'd0;
      sawcr_nxt   = 1'b0;
      lead_nxt    = LEAD_START;
      halt_nxt    = HALT_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      lso_r     <= '0;
      col_r     <= 4'd0;
      cand_r    <= 4'hF;
      found_r   <= 4'd0;
      matched_r <= 1'b0;
      idx_r     <= 2'd0;
      sawcr_r   <= 1'b0;
      done_r    <= 1'b0;
      lead_r    <= LEAD_START;
      halt_r    <= HALT_RUN;
    end else if (fire) begin
      pos_r     <= pos_nxt;
      lso_r     <= lso_nxt;
      col_r     <= col_nxt;
      cand_r    <= cand_nxt;
      found_r   <= found_nxt;
      matched_r <= matched_nxt;
      idx_r     <= idx_nxt;
      sawcr_r   <= sawcr_nxt;
      done_r    <= done_nxt;
      lead_r    <= lead_nxt;
      halt_r    <= halt_nxt;
    end
  end

  // result assembly: event first, status after it
  always_comb begin
    res0 = '0;
    res1 = '0;
    if (ev_valid) begin
      res0.kind       = ev_kind;
      res0.name_index = (ev_kind == hhnf_pkg::EV_FOUND) ? idx_e : 2'd0;
      res0.offset     = off16;
      res0.status     = hhnf_pkg::ST_COMPLETE;
      res0.last       = !stage_fin_r;
      res1.kind       = hhnf_pkg::EV_STATUS;
      res1.status     = status;
      res1.last       = 1'b1;
    end else begin
      res0.kind   = hhnf_pkg::EV_STATUS;
      res0.status = status;
      res0.last   = 1'b1;
    end
  end

  assign push0 = fire && (ev_valid || stage_fin_r);
  assign push1 = fire && ev_valid && stage_fin_r;

  hhnf_result_fifo u_result_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push0_i(push0),
    .data0_i(res0),
    .push1_i(push1),
    .data1_i(res1),
    .room_o (room),
    .valid_o(out_tvalid),
    .ready_i(out_tready),
    .data_o (res_out)
  );

  assign out_tdata = {4'd0, res_out.status, res_out.offset, res_out.name_index};
  assign out_tuser = res_out.kind;
  assign out_tlast = res_out.last;

  // end of headers is set only by a blank-line result
  a_done_from_blank: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(fire && ev_valid && ev_kind == hhnf_pkg::EV_END))
    else $error("section end without blank-line result");

  // a buffer's last byte leaves a fresh buffer state
  a_buffer_restart: assert property (@(posedge clk) disable iff (!rst_n)
    $past(fire && stage_fin_r) |->
      (col_r == 4'd0 && lead_r == LEAD_START && halt_r == HALT_RUN && pos_r == '0))
    else $error("buffer state not cleared after last byte");

  // found names are never withdrawn
  a_found_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((found_r & $past(found_r)) == $past(found_r)))
    else $error("found mask lost a bit");

  // two results only come from a buffer's last byte
  a_pair_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> (push0 && stage_fin_r && ev_valid))
    else $error("second result without last byte");

endmodule

// ===== tb/http_header_name_finder_tb.sv =====
module http_header_name_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BYTES    = 130;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [1:0] {LEAD_NONE, LEAD_AFTER_CR, LEAD_AFTER_LF, LEAD_START} lead_t;
  typedef enum logic [1:0] {SCAN_RUN, SCAN_LF_CR, SCAN_NUL} scan_halt_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // dut ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // buffer_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [1:0] name_index, [17:2] offset, [19:18] status
  logic [1:0]  out_tuser;          // [1:0] event_kind
  logic        out_tlast;          // final_res
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = 6'd0;
  logic [63:0] cfg_pwdata = 64'd0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  http_header_name_finder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicted parser state and register copy
  logic [63:0] pat_name [4];
  logic [15:0] pat_len;
  logic [3:0]  pat_enable;
  logic [15:0] cur_pos;
  logic [15:0] line_start;
  logic [3:0]  cur_col;
  logic [3:0]  cand_mask;
  logic [3:0]  found_mask;
  logic        line_hit;
  logic [1:0]  hit_index;
  logic        after_cr;
  logic        headers_done;
  lead_t       lead_state;
  scan_halt_t  halt_state;

  hhnf_pkg::result_t step_events[$];
  hhnf_pkg::result_t awaited_events[$];

  // stimulus
  byte_req_t   byte_q[$];
  byte_req_t   next_req;
  logic [7:0]  line_bytes[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_arm = 1'b0;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned idle_cycles;

  // bookkeeping
  int unsigned fail_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned buffers_queued = 0;
  int unsigned events_checked = 0;
  int unsigned names_found = 0;
  int unsigned ends_seen = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  function automatic void start_buffer();
    cur_pos    = 16'd0;
    line_start = 16'd0;
    cur_col    = 4'd0;
    cand_mask  = 4'hF;
    line_hit   = 1'b0;
    hit_index  = 2'd0;
    after_cr   = 1'b0;
    lead_state = LEAD_START;
    halt_state = SCAN_RUN;
  endfunction

  function automatic void reset_parser();
    foreach (pat_name[i]) pat_name[i] = 64'd0;
    pat_len      = 16'd0;
    pat_enable   = 4'hF;
    found_mask   = 4'd0;
    headers_done = 1'b0;
    start_buffer();
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [63:0] val);
    case (idx)
      hhnf_pkg::REG_NAME0, hhnf_pkg::REG_NAME1,
      hhnf_pkg::REG_NAME2, hhnf_pkg::REG_NAME3: pat_name[idx[1:0]] = val;
      hhnf_pkg::REG_LENGTHS: pat_len = val[15:0];
      hhnf_pkg::REG_ENABLE: pat_enable = val[3:0];
      default: ;
    endcase
  endfunction

  function automatic void post_event(logic [1:0] kind, logic [1:0] idx, logic [15:0] off,
                                     logic [1:0] st);
    hhnf_pkg::result_t r;
    r.kind       = kind;
    r.name_index = idx;
    r.offset     = off;
    r.status     = st;
    r.last       = 1'b0;
    step_events.push_back(r);
  endfunction

  // one byte through the line matcher
  function automatic void scan_char(logic [7:0] b, logic fin);
    int unsigned len;
    logic [7:0]  nb;
    // buffer-start skips
    case (lead_state)
      LEAD_START: begin
        lead_state = LEAD_NONE;
        if (!fin && b == hhnf_pkg::CH_CR) begin
          lead_state = LEAD_AFTER_CR;
          return;
        end
        if (!fin && b == hhnf_pkg::CH_LF) begin
          lead_state = LEAD_AFTER_LF;
          return;
        end
      end
      LEAD_AFTER_CR: begin
        lead_state = LEAD_NONE;
        if (b == hhnf_pkg::CH_LF) return;
      end
      LEAD_AFTER_LF: begin
        lead_state = LEAD_NONE;
        if (b == hhnf_pkg::CH_CR) begin
          halt_state = SCAN_LF_CR;
          return;
        end
      end
      default: ;
    endcase
    // new line
    if (cur_col == 4'd0) begin
      line_start = cur_pos;
      cand_mask  = pat_enable & ~found_mask;
      line_hit   = 1'b0;
      hit_index  = 2'd0;
      after_cr   = 1'b0;
      if (fin) return;
    end
    if (b == hhnf_pkg::CH_NUL) begin
      halt_state = SCAN_NUL;
      return;
    end
    // line closed by cr lf
    if (after_cr && b == hhnf_pkg::CH_LF) begin
      if (cur_col == 4'd1) begin
        post_event(hhnf_pkg::EV_END, 2'd0, line_start, hhnf_pkg::ST_COMPLETE);
        headers_done = 1'b1;
      end else if (line_hit) begin
        post_event(hhnf_pkg::EV_FOUND, hit_index, line_start, hhnf_pkg::ST_COMPLETE);
        found_mask[hit_index] = 1'b1;
      end
      cur_col  = 4'd0;
      after_cr = 1'b0;
      line_hit = 1'b0;
      return;
    end
    // compare against every live name, lowest hit wins
    for (int i = 0; i < 4; i++) begin
      if (cand_mask[i]) begin
        len = pat_len[4*i +: 4];
        if (len > 8) len = 8;
        if (cur_col < len) begin
          nb = pat_name[i][8*cur_col +: 8];
          if (fold_case(b) != fold_case(nb)) cand_mask[i] = 1'b0;
        end else begin
          if (cur_col == len && b == hhnf_pkg::CH_COLON && (!line_hit || i < hit_index)) begin
            line_hit  = 1'b1;
            hit_index = 2'(i);
          end
          cand_mask[i] = 1'b0;
        end
      end
    end
    after_cr = (b == hhnf_pkg::CH_CR);
    if (cur_col < 4'd15) cur_col = cur_col + 4'd1;
  endfunction

  function automatic void advance_parser(logic [7:0] b, logic fin);
    logic [1:0] st;
    step_events.delete();
    if (!headers_done && halt_state == SCAN_RUN) scan_char(b, fin);
    cur_pos = cur_pos + 16'd1;
    if (fin) begin
      if (headers_done || halt_state == SCAN_LF_CR) st = hhnf_pkg::ST_COMPLETE;
      else if (halt_state == SCAN_NUL || cur_col != 4'd0) st = hhnf_pkg::ST_UNTERM;
      else st = hhnf_pkg::ST_LINE_END;
      post_event(hhnf_pkg::EV_STATUS, 2'd0, 16'd0, st);
      start_buffer();
    end
    if (step_events.size() != 0) step_events[step_events.size()-1].last = 1'b1;
    foreach (step_events[k]) awaited_events.push_back(step_events[k]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void report_fail(string what, hhnf_pkg::result_t want,
                                      hhnf_pkg::result_t got);
    if (fail_count < MAX_REPORTS) begin
      $display("%s at %0t: expected kind %0d name %0d offset %0d status %0d last %0d",
               what, $time, want.kind, want.name_index, want.offset, want.status,
               want.last);
      $display("  got kind %0d name %0d offset %0d status %0d last %0d",
               got.kind, got.name_index, got.offset, got.status, got.last);
    end
    fail_count++;
  endfunction

  function automatic void check_event();
    hhnf_pkg::result_t got;
    hhnf_pkg::result_t want;
    got.kind       = out_tuser;
    got.name_index = out_tdata[1:0];
    got.offset     = out_tdata[17:2];
    got.status     = out_tdata[19:18];
    got.last       = out_tlast;
    events_checked++;
    if (awaited_events.size() == 0) begin
      want = '0;
      report_fail("unexpected result", want, got);
    end else begin
      want = awaited_events.pop_front();
      if (got !== want || out_tdata[23:20] !== 4'h0) begin
        report_fail("result mismatch", want, got);
      end else if (want.kind == hhnf_pkg::EV_FOUND) begin
        names_found++;
      end else if (want.kind == hhnf_pkg::EV_END) begin
        ends_seen++;
      end
    end
  endfunction

  // register writes, accepted bytes and results, in that order
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_parser();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        apply_register(cfg_paddr[5:3], cfg_pwdata);
      end
      if (in_tvalid && in_tready) begin
        advance_parser(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        check_event();
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- driver side

  // byte sender with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_req.data;
        in_tlast  <= next_req.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_tvalid || awaited_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- buffer builders

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [7:0] name_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return 8'($urandom_range(8'h61, 8'h7A));
    if (pick < 80) return 8'($urandom_range(8'h41, 8'h5A));
    if (pick < 95) return 8'h2D;
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [63:0] rand_name();
    logic [63:0] v;
    for (int k = 0; k < 8; k++) v[8*k +: 8] = name_char();
    return v;
  endfunction

  function automatic logic [15:0] rand_lengths();
    logic [15:0] v;
    int unsigned pick;
    for (int i = 0; i < 4; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) v[4*i +: 4] = 4'd0;
      else if (pick < 16) v[4*i +: 4] = 4'($urandom_range(9, 15));
      else v[4*i +: 4] = 4'($urandom_range(1, 8));
    end
    return v;
  endfunction

  function automatic void add_crlf();
    line_bytes.push_back(hhnf_pkg::CH_CR);
    line_bytes.push_back(hhnf_pkg::CH_LF);
  endfunction

  // a line built from one of the names, exact or slightly off
  function automatic void add_name_line(bit exact);
    int unsigned idx;
    int unsigned len;
    int unsigned how;
    logic [7:0]  c;
    idx = $urandom_range(3);
    len = pat_len[4*idx +: 4];
    if (len > 8) len = 8;
    how = $urandom_range(3);
    for (int k = 0; k < len; k++) begin
      c = pat_name[idx][8*k +: 8];
      if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1)) c = c ^ 8'h20;
      if (!exact && how == 0 && k == len - 1) c = c ^ 8'h01;
      line_bytes.push_back(c);
    end
    if (!exact && how == 1) line_bytes.push_back(name_char());
    if (!exact && how == 2) line_bytes.push_back(8'h20);
    if (exact || how != 3) line_bytes.push_back(hhnf_pkg::CH_COLON);
    repeat ($urandom_range(0, 5)) line_bytes.push_back(printable());
    add_crlf();
  endfunction

  function automatic void add_header_line();
    repeat ($urandom_range(1, 6)) line_bytes.push_back(name_char());
    line_bytes.push_back(hhnf_pkg::CH_COLON);
    line_bytes.push_back(8'h20);
    repeat ($urandom_range(0, 5)) line_bytes.push_back(printable());
    add_crlf();
  endfunction

  // move the built buffer into the send queue, tlast on its final byte
  function automatic void flush_buffer();
    byte_req_t req;
    if (line_bytes.size() == 0) line_bytes.push_back(printable());
    foreach (line_bytes[k]) begin
      req.data = line_bytes[k];
      req.last = (k == line_bytes.size() - 1);
      byte_q.push_back(req);
    end
    bytes_queued += line_bytes.size();
    buffers_queued++;
    line_bytes.delete();
  endfunction

  function automatic void add_random_buffer(bit allow_blank);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // raw noise
      repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(255)));
    end else begin
      // leading line breaks
      if (pick < 14) begin
        add_crlf();
      end else if (pick < 18) begin
        line_bytes.push_back(hhnf_pkg::CH_CR);
      end else if (pick < 22) begin
        line_bytes.push_back(hhnf_pkg::CH_LF);
      end else if (pick < 25) begin
        line_bytes.push_back(hhnf_pkg::CH_LF);
        line_bytes.push_back(hhnf_pkg::CH_CR);
      end
      repeat ($urandom_range(0, 3)) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          add_name_line(1'b1);
        end else if (pick < 35) begin
          add_name_line(1'b0);
        end else if (pick < 65) begin
          add_header_line();
        end else if (pick < 78) begin
          repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(1, 255)));
          add_crlf();
        end else if (pick < 84) begin
          line_bytes.push_back(printable());
          line_bytes.push_back(hhnf_pkg::CH_NUL);
          line_bytes.push_back(printable());
          add_crlf();
        end else if (pick < 92) begin
          line_bytes.push_back(printable());
          line_bytes.push_back($urandom_range(1) ? hhnf_pkg::CH_CR : hhnf_pkg::CH_LF);
          line_bytes.push_back(printable());
          add_crlf();
        end else if (allow_blank) begin
          add_crlf();
        end else begin
          add_header_line();
        end
      end
      // tail: closed, partial line, or a lone byte
      pick = $urandom_range(99);
      if (pick < 30) begin
        repeat ($urandom_range(1, 5)) line_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 45) begin
        line_bytes.push_back(8'($urandom_range(255)));
      end
    end
    flush_buffer();
  endfunction

  function automatic void fill_phase();
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < PHASE_BYTES) add_random_buffer(1'b0);
  endfunction

  task automatic program_names();
    for (int i = 0; i < 4; i++) write_reg(3'(hhnf_pkg::REG_NAME0 + i), rand_name());
    write_reg(hhnf_pkg::REG_LENGTHS, {48'd0, rand_lengths()});
    write_reg(hhnf_pkg::REG_ENABLE, {60'd0, 4'($urandom_range(15))});
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset names: all empty, so a leading colon hits every one
    line_bytes = '{8'h41};
    flush_buffer();
    line_bytes = '{hhnf_pkg::CH_CR};
    flush_buffer();
    line_bytes = '{hhnf_pkg::CH_LF, hhnf_pkg::CH_CR};
    flush_buffer();
    line_bytes = '{hhnf_pkg::CH_CR, hhnf_pkg::CH_LF, hhnf_pkg::CH_COLON, 8'h61,
                   hhnf_pkg::CH_CR, hhnf_pkg::CH_LF};
    flush_buffer();
    line_bytes = '{8'h61, hhnf_pkg::CH_NUL, 8'h62, hhnf_pkg::CH_LF};
    flush_buffer();
    line_bytes = '{hhnf_pkg::CH_COLON, 8'h78};
    flush_buffer();
    line_bytes = '{8'h61, hhnf_pkg::CH_CR, hhnf_pkg::CH_LF, 8'h62};
    flush_buffer();
    wait_idle();

    // extremes: zero and all-ones names, every length clamped
    write_reg(hhnf_pkg::REG_NAME0, 64'd0);
    write_reg(hhnf_pkg::REG_NAME1, '1);
    write_reg(hhnf_pkg::REG_NAME2, rand_name());
    write_reg(hhnf_pkg::REG_NAME3, rand_name());
    write_reg(hhnf_pkg::REG_LENGTHS, 64'hFFFF);
    write_reg(hhnf_pkg::REG_ENABLE, 64'hF);

    // no idling, long receiver hold while bytes keep coming
    hold_arm = 1'b1;
    fill_phase();
    wait_idle();

    program_names();
    send_idle_pct  = 65;
    recv_stall_pct = 0;
    fill_phase();
    wait_idle();

    program_names();
    send_idle_pct  = 0;
    recv_stall_pct = 65;
    fill_phase();
    wait_idle();

    program_names();
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    fill_phase();
    wait_idle();

    // buffer closed by a blank line, then buffers after the section
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(hhnf_pkg::REG_ENABLE, 64'd0);
    repeat (3) add_header_line();
    add_crlf();
    flush_buffer();
    repeat (3) add_random_buffer(1'b1);
    wait_idle();

    if (awaited_events.size() != 0) begin
      $display("%0d expected results never arrived", awaited_events.size());
      fail_count += awaited_events.size();
    end
    $display("sent %0d bytes in %0d buffers under four idle mixes and one long output hold",
             bytes_queued, buffers_queued);
    $display("checked %0d results: %0d names found, %0d header section ends, %0d failures",
             events_checked, names_found, ends_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
